FILE: hdl/mpsi_pkg.sv
// Shared types and constants for the motor power safety interlock.
package mpsi_pkg;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned TimeoutWidth = 16;
  localparam int unsigned LimitWidth   = 7;
  localparam int unsigned PeriodWidth  = 8;
  localparam int unsigned InDataWidth  = 24;
  localparam int unsigned OutDataWidth = 16;

  localparam logic [TimeoutWidth-1:0] TimeoutReset = 16'd100;
  localparam logic [LimitWidth-1:0]   LimitReset   = 7'd85;
  localparam logic [PeriodWidth-1:0]  PeriodReset  = 8'd20;

  localparam logic [CfgIdxWidth-1:0] CfgHostTimeout  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgOvertempLim  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgStatusPeriod = 2'd2;

  typedef enum logic [2:0] {
    MSG_PING      = 3'd0,
    MSG_ENABLE    = 3'd1,
    MSG_DISABLE   = 3'd2,
    MSG_CLEAR     = 3'd3,
    MSG_REPORT    = 3'd4
  } msg_e;

  localparam logic [7:0] FltEstop     = 8'h01;
  localparam logic [7:0] FltOvertemp  = 8'h02;
  localparam logic [7:0] FltJoint     = 8'h04;
  localparam logic [7:0] FltWatchdog  = 8'h08;
  localparam logic [7:0] FltSilent    = 8'h10;
  localparam logic [7:0] FltClearable = FltOvertemp | FltJoint | FltWatchdog | FltSilent;

  typedef struct packed {
    logic [TimeoutWidth-1:0] host_timeout;
    logic [LimitWidth-1:0]   overtemp_limit;
    logic [PeriodWidth-1:0]  status_period;
  } cfg_t;

  typedef struct packed {
    logic              is_tick;
    logic [2:0]        msg_type;
    logic              has_payload;
    logic [7:0]        report_bits;
    logic              estop_pressed;
    logic signed [7:0] motor_temp;
    logic              joint_limit_hit;
  } item_t;

  typedef struct packed {
    logic       contactor_closed;
    logic [7:0] fault_flags;
    logic       host_alive;
    logic       status_due;
  } result_t;

endpackage

FILE: hdl/mpsi_core.sv
// Interlock state registers and the per-transaction update logic.
module mpsi_core #(
  parameter int unsigned SILENCE_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  mpsi_pkg::item_t  item_i,
  input  mpsi_pkg::cfg_t   cfg_i,
  output mpsi_pkg::result_t result_o
);
  import mpsi_pkg::*;

  localparam int unsigned CmpWidth =
      (SILENCE_WIDTH > TimeoutWidth) ? SILENCE_WIDTH : TimeoutWidth;

  logic                     estop_q, estop_d;
  logic                     req_q, req_d;
  logic                     pwr_q, pwr_d;
  logic [7:0]               flt_q, flt_d;
  logic [SILENCE_WIDTH-1:0] sil_q, sil_d;
  logic [PeriodWidth-1:0]   cnt_q, cnt_d;
  logic                     alive;
  logic                     due;
  logic                     hot;

  assign hot   = item_i.motor_temp >= $signed({1'b0, cfg_i.overtemp_limit});

  always_comb begin
    estop_d = estop_q;
    req_d   = req_q;
    pwr_d   = pwr_q;
    flt_d   = flt_q;
    sil_d   = sil_q;
    cnt_d   = cnt_q;
    due     = 1'b0;
    alive   = 1'b0;
    if (!item_i.is_tick) begin
      sil_d = '0;
      alive = CmpWidth'(sil_d) < CmpWidth'(cfg_i.host_timeout);
      case (item_i.msg_type)
        MSG_PING: ;
        MSG_ENABLE:    req_d = 1'b1;
        MSG_DISABLE: begin
          req_d = 1'b0;
          pwr_d = 1'b0;
        end
        MSG_CLEAR:     flt_d = flt_q & ~FltClearable;
        MSG_REPORT: begin
          if (item_i.has_payload) begin
            flt_d = flt_q | item_i.report_bits;
            pwr_d = 1'b0;
          end
        end
        default:       pwr_d = 1'b0;
      endcase
    end else begin
      if (sil_q != '1) sil_d = sil_q + 1'b1;
      alive = CmpWidth'(sil_d) < CmpWidth'(cfg_i.host_timeout);
      if (item_i.estop_pressed) begin
        estop_d = 1'b1;
        flt_d   = flt_d | FltEstop;
      end
      if (hot)                    flt_d = flt_d | FltOvertemp;
      if (item_i.joint_limit_hit) flt_d = flt_d | FltJoint;
      if (!alive)                 flt_d = flt_d | FltSilent;
      pwr_d = req_q && !estop_d && (flt_d == '0) && alive;
      if (cnt_q == '0) begin
        due   = 1'b1;
        cnt_d = (cfg_i.status_period == '0) ? '0 : cfg_i.status_period - 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  assign result_o = '{contactor_closed: pwr_d, fault_flags: flt_d,
                      host_alive: alive, status_due: due};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      estop_q <= 1'b0;
      req_q   <= 1'b0;
      pwr_q   <= 1'b0;
      flt_q   <= '0;
      sil_q   <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      estop_q <= estop_d;
      req_q   <= req_d;
      pwr_q   <= pwr_d;
      flt_q   <= flt_d;
      sil_q   <= sil_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_closed_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pwr_q |-> (flt_q == '0) && !estop_q)
    else $error("contactor closed with a fault pending");
  a_closed_requested: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pwr_q |-> req_q)
    else $error("contactor closed without a power request");
  a_estop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(estop_q))
    else $error("estop latch cleared without reset");
  a_estop_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    estop_q |-> flt_q[0])
    else $error("estop latched but fault bit clear");
`endif

endmodule

FILE: hdl/motor_power_safety_interlock.sv
// Top level: stream handshake, configuration registers and result register.
//
// Safety interlock for a motor power contactor. Each input transaction (a host
// frame or a 1 ms tick) yields one result transaction. An item is captured in an
// input register, evaluated by compare and flag logic against the interlock
// state, and written to the output register; a new item is accepted every
// cycle while the output is drained, so throughput is one item per clock
// unless the output stalls. Configuration writes are always accepted and take
// effect for the next item.
module motor_power_safety_interlock #(
  parameter int unsigned SILENCE_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [2:0] msg_type, [3] has_payload, [11:4] report_bits, [12] estop_pressed,
  // [20:13] motor_temp, [21] joint_limit_hit, [23:22] zero
  input  logic [mpsi_pkg::InDataWidth-1:0]    s_axis_tdata,
  // [0] is_tick
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] contactor_closed, [8:1] fault_flags, [9] host_alive, [10] status_due,
  // [15:11] zero
  output logic [mpsi_pkg::OutDataWidth-1:0]   m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mpsi_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [mpsi_pkg::CfgDataWidth-1:0]   cfg_data_i
);
  import mpsi_pkg::*;

  cfg_t    cfg_q;
  item_t   item_q;
  logic    in_vld_q;
  result_t res_q, res_d;
  logic    out_vld_q;
  logic    step;

  assign step          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || step;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{host_timeout: TimeoutReset, overtemp_limit: LimitReset,
                 status_period: PeriodReset};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgHostTimeout:  cfg_q.host_timeout   <= cfg_data_i[TimeoutWidth-1:0];
        CfgOvertempLim:  cfg_q.overtemp_limit <= cfg_data_i[LimitWidth-1:0];
        CfgStatusPeriod: cfg_q.status_period  <= cfg_data_i[PeriodWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (!out_vld_q || m_axis_tready) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= '{is_tick: s_axis_tuser, msg_type: s_axis_tdata[2:0],
                  has_payload: s_axis_tdata[3], report_bits: s_axis_tdata[11:4],
                  estop_pressed: s_axis_tdata[12],
                  motor_temp: $signed(s_axis_tdata[20:13]),
                  joint_limit_hit: s_axis_tdata[21]};
    end
    if (step) res_q <= res_d;
  end

  mpsi_core #(
    .SILENCE_WIDTH(SILENCE_WIDTH)
  ) u_core (
    .clk_i,
    .rst_ni,
    .step_i  (step),
    .item_i  (item_q),
    .cfg_i   (cfg_q),
    .result_o(res_d)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, res_q.status_due, res_q.host_alive,
                          res_q.fault_flags, res_q.contactor_closed};

endmodule

FILE: tb/sv/motor_power_safety_interlock_test.sv
// Self-checking testbench for the motor power safety interlock.
module motor_power_safety_interlock_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mpsi_pkg::*;

  localparam logic [2:0]  MsgRsvd5    = 3'd5;
  localparam logic [2:0]  MsgRsvd6    = 3'd6;
  localparam logic [2:0]  MsgRsvd7    = 3'd7;
  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned SteadyTicks = 200;

  class interlock_scoreboard;
    logic [TimeoutWidth-1:0] host_timeout;
    logic [LimitWidth-1:0]   temp_limit;
    logic [PeriodWidth-1:0]  status_period;
    logic                    stop_held;
    logic                    power_wanted;
    logic                    contactor_on;
    logic [7:0]              faults;
    logic [15:0]             silence;
    logic [7:0]              countdown;
    result_t                 expected_status[$];
    int unsigned             mismatches;
    int unsigned             items_taken;
    int unsigned             results_seen;
    int unsigned             closed_seen;
    int unsigned             due_seen;
    int unsigned             reg_writes;

    function new();
      host_timeout  = TimeoutReset;
      temp_limit    = LimitReset;
      status_period = PeriodReset;
      stop_held     = 1'b0;
      power_wanted  = 1'b0;
      contactor_on  = 1'b0;
      faults        = '0;
      silence       = '0;
      countdown     = '0;
    endfunction

    function void write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
      reg_writes++;
      case (idx)
        CfgHostTimeout:  host_timeout  = val[TimeoutWidth-1:0];
        CfgOvertempLim:  temp_limit    = val[LimitWidth-1:0];
        CfgStatusPeriod: status_period = val[PeriodWidth-1:0];
        default: ;
      endcase
    endfunction

    function bit host_alive();
      return silence < host_timeout;
    endfunction

    function void open_with(logic [7:0] bits);
      faults       = faults | bits;
      contactor_on = 1'b0;
    endfunction

    function void take_item(item_t it);
      result_t r;
      int      temp_c;
      logic    due;
      due = 1'b0;
      items_taken++;
      if (!it.is_tick) begin
        silence = '0;
        case (it.msg_type)
          MSG_PING: ;
          MSG_ENABLE:    power_wanted = 1'b1;
          MSG_DISABLE: begin
            power_wanted = 1'b0;
            contactor_on = 1'b0;
          end
          MSG_CLEAR:     faults = faults & ~FltClearable;
          MSG_REPORT:    if (it.has_payload) open_with(it.report_bits);
          default:       open_with('0);
        endcase
      end else begin
        if (silence != '1) silence++;
        temp_c = $signed(it.motor_temp);
        if (it.estop_pressed) begin
          stop_held = 1'b1;
          open_with(FltEstop);
        end
        if (temp_c >= int'(temp_limit)) open_with(FltOvertemp);
        if (it.joint_limit_hit) open_with(FltJoint);
        if (!host_alive()) open_with(FltSilent);
        contactor_on = power_wanted && !stop_held && faults == '0 && host_alive();
        if (countdown == '0) begin
          due       = 1'b1;
          countdown = (status_period == '0) ? '0 : status_period - 8'd1;
        end else begin
          countdown--;
        end
      end
      r.contactor_closed = contactor_on;
      r.fault_flags      = faults;
      r.host_alive       = host_alive();
      r.status_due       = due;
      expected_status.push_back(r);
    endfunction

    function void flag(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: closed/faults/alive/due want %0b/%02h/%0b/%0b got %0b/%02h/%0b/%0b",
                 what, want.contactor_closed, want.fault_flags, want.host_alive,
                 want.status_due, got.contactor_closed, got.fault_flags,
                 got.host_alive, got.status_due);
    endfunction

    function void check_status(logic [OutDataWidth-1:0] d);
      result_t got;
      result_t want;
      got.contactor_closed = d[0];
      got.fault_flags      = d[8:1];
      got.host_alive       = d[9];
      got.status_due       = d[10];
      results_seen++;
      if (expected_status.size() == 0) begin
        flag("status with no item pending", '0, got);
        return;
      end
      want = expected_status.pop_front();
      if (want.contactor_closed) closed_seen++;
      if (want.status_due) due_seen++;
      if (got !== want) flag($sformatf("status mismatch at result %0d", results_seen), want, got);
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata;
  logic                    s_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CfgIdxWidth-1:0]  cfg_index_i;
  logic [CfgDataWidth-1:0] cfg_data_i;

  interlock_scoreboard sb = new();
  item_t       offered;
  bit          steady;
  bit          stall_req;
  int unsigned stall_left;
  int unsigned cycles;

  motor_power_safety_interlock dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.take_item(offered);
    end
  end

  initial begin
    m_axis_tready <= 1'b0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        stall_req  = 1'b0;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 30);
      end
    end
  end

  function automatic item_t frame(logic [2:0] msg, logic payload, logic [7:0] bits);
    item_t it;
    it             = '0;
    it.msg_type    = msg;
    it.has_payload = payload;
    it.report_bits = bits;
    return it;
  endfunction

  function automatic item_t tick(logic estop, int temp, logic joint);
    item_t it;
    it                 = '0;
    it.is_tick         = 1'b1;
    it.estop_pressed   = estop;
    it.motor_temp      = temp[7:0];
    it.joint_limit_hit = joint;
    return it;
  endfunction

  function automatic item_t rand_tick(bit sticky, logic [LimitWidth-1:0] lim);
    item_t it;
    int    t;
    it.is_tick         = 1'b1;
    it.msg_type        = 3'($urandom);
    it.has_payload     = 1'($urandom);
    it.report_bits     = 8'($urandom);
    it.estop_pressed   = sticky && ($urandom_range(99) < 5);
    it.joint_limit_hit = $urandom_range(99) < 4;
    if (lim > 0 && $urandom_range(99) < 90) t = int'($urandom_range(lim + 127)) - 128;
    else t = int'($urandom_range(255)) - 128;
    it.motor_temp = t[7:0];
    return it;
  endfunction

  function automatic item_t rand_frame(bit sticky);
    item_t       it;
    int unsigned pct;
    it.is_tick         = 1'b0;
    it.estop_pressed   = 1'($urandom);
    it.motor_temp      = 8'($urandom);
    it.joint_limit_hit = 1'($urandom);
    it.has_payload     = 1'($urandom);
    it.report_bits     = 8'($urandom);
    if (!sticky) it.report_bits = it.report_bits & FltClearable;
    pct = $urandom_range(99);
    if (pct < 25)      it.msg_type = MSG_PING;
    else if (pct < 47) it.msg_type = MSG_ENABLE;
    else if (pct < 55) it.msg_type = MSG_DISABLE;
    else if (pct < 75) it.msg_type = MSG_CLEAR;
    else if (pct < 93) it.msg_type = MSG_REPORT;
    else               it.msg_type = 3'($urandom_range(MsgRsvd7, MsgRsvd5));
    return it;
  endfunction

  task automatic send_item(input item_t it);
    while (!steady && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    offered = it;
    s_axis_tdata  <= {2'b00, it.joint_limit_hit, it.motor_temp, it.estop_pressed,
                      it.report_bits, it.has_payload, it.msg_type};
    s_axis_tuser  <= it.is_tick;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // drain all pending status, then let the pipeline go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_status.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_regs(input logic [CfgDataWidth-1:0] timeout_ticks,
                            input logic [CfgDataWidth-1:0] limit,
                            input logic [CfgDataWidth-1:0] period);
    logic [CfgIdxWidth-1:0]  idx[3];
    logic [CfgDataWidth-1:0] val[3];
    idx = '{CfgHostTimeout, CfgOvertempLim, CfgStatusPeriod};
    val = '{timeout_ticks, limit, period};
    for (int k = 0; k < 3; k++) begin
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(idx[k], val[k]);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_random(input int unsigned n, input bit sticky);
    for (int i = 0; i < n; i++) begin
      if (i == n / 4) settle();
      if (i == n / 2) stall_req = 1'b1;
      send_item($urandom_range(99) < 45 ? rand_tick(sticky, sb.temp_limit) : rand_frame(sticky));
    end
    settle();
  endtask

  initial begin
    item_t noisy;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    steady    = 1'b0;
    stall_req = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset configuration
    send_item(tick(1'b0, -128, 1'b0));
    send_item(frame(MSG_ENABLE, 1'b0, 8'h00));
    send_item(tick(1'b0, 84, 1'b0));
    send_item(frame(MSG_REPORT, 1'b0, 8'hFF));
    send_item(tick(1'b0, 85, 1'b0));
    send_item(frame(MSG_CLEAR, 1'b0, 8'h00));
    send_item(tick(1'b0, 0, 1'b0));
    send_item(frame(MsgRsvd5, 1'b1, 8'h00));
    send_item(tick(1'b0, 0, 1'b0));
    send_item(frame(MsgRsvd6, 1'b0, 8'h00));
    send_item(frame(MsgRsvd7, 1'b1, 8'hFF));
    send_item(tick(1'b0, -1, 1'b1));
    send_item(frame(MSG_REPORT, 1'b1, FltWatchdog));
    send_item(frame(MSG_CLEAR, 1'b0, 8'h00));
    noisy = frame(MSG_PING, 1'b1, 8'hFF);
    noisy.estop_pressed   = 1'b1;
    noisy.motor_temp      = 8'sd127;
    noisy.joint_limit_hit = 1'b1;
    send_item(noisy);
    noisy = tick(1'b0, 127, 1'b0);
    noisy.msg_type    = MsgRsvd7;
    noisy.has_payload = 1'b1;
    noisy.report_bits = 8'hFF;
    send_item(noisy);
    send_item(frame(MSG_DISABLE, 1'b0, 8'h00));
    settle();

    write_regs(16'd1, 16'd0, 16'd1);
    run_random(150, 1'b0);
    write_regs(16'hFFFF, 16'd127, 16'd255);
    run_random(150, 1'b0);
    // zero timeout: never alive; zero period: every tick marked
    write_regs(16'd0, 16'd60, 16'd0);
    run_random(60, 1'b0);

    // back-to-back ticks with no idling on either side
    write_regs(16'hFFFF, 16'd127, 16'd255);
    send_item(frame(MSG_ENABLE, 1'b0, 8'h00));
    steady = 1'b1;
    repeat (SteadyTicks) send_item(rand_tick(1'b0, sb.temp_limit));
    steady = 1'b0;
    settle();

    repeat (5) begin
      write_regs(16'($urandom_range(99) < 80 ? $urandom_range(40, 1) : $urandom_range(65535, 1)),
                 16'($urandom_range(127)),
                 16'($urandom_range(99) < 70 ? $urandom_range(12, 1) : $urandom_range(255, 1)));
      run_random(220, 1'b0);
    end

    // latching faults last: estop and reported bits that clear cannot remove
    write_regs(16'd50, 16'd90, 16'd3);
    send_item(frame(MSG_CLEAR, 1'b0, 8'h00));
    send_item(frame(MSG_ENABLE, 1'b0, 8'h00));
    send_item(tick(1'b0, 20, 1'b0));
    send_item(frame(MSG_REPORT, 1'b1, 8'hE0));
    send_item(frame(MSG_CLEAR, 1'b0, 8'h00));
    send_item(tick(1'b1, 20, 1'b0));
    send_item(frame(MSG_CLEAR, 1'b0, 8'h00));
    send_item(tick(1'b0, 20, 1'b0));
    send_item(frame(MSG_REPORT, 1'b1, FltEstop));
    run_random(150, 1'b1);

    s_axis_tvalid <= 1'b0;
    while (sb.expected_status.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("%0d items, %0d status results, %0d register writes over %0d cycles",
             sb.items_taken, sb.results_seen, sb.reg_writes, cycles);
    $display("contactor closed in %0d results, status marks in %0d, %0d mismatches",
             sb.closed_seen, sb.due_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_status.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/mpsi_pkg.sv
hdl/mpsi_core.sv
hdl/motor_power_safety_interlock.sv
tb/sv/motor_power_safety_interlock_test.sv
